/* rtl/core/chbi_pkg.sv */
// Shared types and constants for the chained bucket hash index.
`timescale 1ns / 1ps
package chbi_pkg;

    localparam int NAME_LOW_W  = 64;
    localparam int NAME_HIGH_W = 56;
    localparam int NAME_W      = NAME_LOW_W + NAME_HIGH_W;
    localparam int NAME_BYTES  = 15;
    localparam int DBLK_W      = 16;
    localparam int STATUS_W    = 3;
    localparam int VISIT_W     = 8;
    localparam int SUM_W       = 12;
    localparam int NB_REG_W    = 9;
    localparam int CAP_REG_W   = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int MATCH_W     = 6;
    localparam logic [MATCH_W-1:0] MAX_MATCHES = 6'd63;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_MATCH     = 3'd1,
        ST_DONE      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_TRUNC     = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_BUCKETS = 1'b0,
        REG_BLOCK_CAP   = 1'b1
    } t_reg_idx;

    localparam logic MODE_INSERT = 1'b0;

endpackage

/* rtl/core/chbi_ifs.sv */
// Request, result and configuration channel interfaces.
`timescale 1ns / 1ps
interface chbi_req_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [chbi_pkg::NAME_LOW_W-1:0]  name_low;
    logic [chbi_pkg::NAME_HIGH_W-1:0] name_high;
    logic [chbi_pkg::DBLK_W-1:0]      data_block;
    modport source (output valid, mode, name_low, name_high, data_block, input ready);
    modport sink (input valid, mode, name_low, name_high, data_block, output ready);
endinterface

interface chbi_res_if;
    logic                          valid;
    logic                          ready;
    logic [chbi_pkg::STATUS_W-1:0] status;
    logic [chbi_pkg::DBLK_W-1:0]   result_block;
    logic [chbi_pkg::VISIT_W-1:0]  blocks_visited;
    logic                          last;
    modport source (output valid, status, result_block, blocks_visited, last, input ready);
    modport sink (input valid, status, result_block, blocks_visited, last, output ready);
endinterface

interface chbi_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [chbi_pkg::CFG_IDX_W-1:0]  index;
    logic [chbi_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/chbi_hash.sv */
// Name cleanup, byte sum and bit-serial modulo by the bucket count.
`timescale 1ns / 1ps
module chbi_hash #(
    parameter int NAME_CHARS = 15,
    parameter int NBW        = 9,
    parameter int BKW        = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [chbi_pkg::NAME_W-1:0] i_name,
    input  logic [NBW-1:0]              i_nb,
    output logic                        o_done,
    output logic [chbi_pkg::NAME_W-1:0] o_name,
    output logic [BKW-1:0]              o_bucket
);
    import chbi_pkg::*;

    logic               r_busy, r_mod, r_done, r_ended;
    logic [3:0]         r_cnt;
    logic [NAME_W-1:0]  r_name;
    logic [SUM_W-1:0]   r_sum;
    logic [NBW-1:0]     r_rem;
    logic [NBW-1:0]     r_nb;

    logic [7:0]   byte_in, byte_cl;
    logic         ends;
    logic [NBW:0] trial;
    logic [NBW-1:0] n_rem;

    assign byte_in = r_name[7:0];
    assign ends    = r_ended || (32'(r_cnt) >= NAME_CHARS) || (byte_in == 8'd0);
    assign byte_cl = ends ? 8'd0 : byte_in;
    assign trial   = {r_rem, r_sum[SUM_W-1]};
    assign n_rem   = (trial >= {1'b0, r_nb}) ? NBW'(trial - {1'b0, r_nb}) : NBW'(trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mod  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy  <= 1'b1;
                r_mod   <= 1'b0;
                r_cnt   <= 4'd0;
                r_ended <= 1'b0;
                r_name  <= i_name;
                r_sum   <= '0;
                r_nb    <= i_nb;
            end else if (r_busy && !r_mod) begin
                // rotate one byte per cycle; after all bytes the name is back in place
                r_name  <= {byte_cl, r_name[NAME_W-1:8]};
                r_sum   <= r_sum + SUM_W'(byte_cl);
                r_ended <= ends;
                if (r_cnt == 4'(NAME_BYTES - 1)) begin
                    r_mod <= 1'b1;
                    r_cnt <= 4'd0;
                    r_rem <= '0;
                end else begin
                    r_cnt <= r_cnt + 4'd1;
                end
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_sum <= {r_sum[SUM_W-2:0], 1'b0};
                if (r_cnt == 4'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 4'd1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_name   = r_name;
    assign o_bucket = BKW'(r_rem);
endmodule

/* rtl/core/chained_bucket_hash_index_core.sv */
// Flow: the hash scans the 15 name bytes and takes 12 modulo steps, then the bucket head is read;
// insert then walks the chain blocks (and links a new block when the last is full), and lookup reads
// each block and each stored pair, with a result per match up to MAX_MATCHES; all go out registered.
// Throughput: one request at a time, ready only while idle; a stalled result holds it.
// Reset (synchronous, active low): clears the bucket heads in one pass over all MAX_BUCKETS
// entries, during which no request is accepted; config writes always taken.
`timescale 1ns / 1ps
module chained_bucket_hash_index_core #(
    parameter int MAX_BLOCKS      = 256,
    parameter int SLOTS_PER_BLOCK = 32,
    parameter int MAX_BUCKETS     = 256,
    parameter int NAME_CHARS      = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chbi_req_if.sink    i_req,
    chbi_res_if.source  o_res,
    chbi_cfg_if.sink    i_cfg
);
    import chbi_pkg::*;

    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int AW   = $clog2(MAX_BLOCKS * SLOTS_PER_BLOCK);
    localparam int FW   = $clog2(SLOTS_PER_BLOCK + 1);
    localparam int BKW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NBW  = $clog2(MAX_BUCKETS + 1);
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int CLRW = BKW + 1;
    localparam int SW   = NAME_W + DBLK_W;
    localparam int BIW  = FW + IW + 1;

    typedef enum logic [14:0] {
        S_CLR      = 15'b000000000000001,
        S_IDLE     = 15'b000000000000010,
        S_HASH     = 15'b000000000000100,
        S_HEAD_RD  = 15'b000000000001000,
        S_HEAD     = 15'b000000000010000,
        S_WALK_RD  = 15'b000000000100000,
        S_WALK     = 15'b000000001000000,
        S_LINK     = 15'b000000010000000,
        S_LBLK_RD  = 15'b000000100000000,
        S_LBLK     = 15'b000001000000000,
        S_LSLOT_RD = 15'b000010000000000,
        S_LSLOT    = 15'b000100000000000,
        S_LADV     = 15'b001000000000000,
        S_LNEXT    = 15'b010000000000000,
        S_EMIT     = 15'b100000000000000
    } t_state;

    // config registers
    logic [NB_REG_W-1:0]  r_nb_reg;
    logic [CAP_REG_W-1:0] r_cap_reg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb_reg  <= NB_REG_W'(16);
            r_cap_reg <= CAP_REG_W'(25);
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_NUM_BUCKETS: r_nb_reg  <= i_cfg.data;
                REG_BLOCK_CAP:   r_cap_reg <= CAP_REG_W'(i_cfg.data);
                default: ;
            endcase
        end
    end
    assign i_cfg.ready = 1'b1;

    logic [12:0] nb13;
    logic [6:0]  cap7;
    logic [NBW-1:0] nb_eff;
    logic [FW-1:0]  cap_eff;

    always_comb begin
        nb13 = 13'(r_nb_reg);
        if (nb13 == 13'd0) nb13 = 13'd1;
        if (nb13 > 13'(MAX_BUCKETS)) nb13 = 13'(MAX_BUCKETS);
        cap7 = 7'(r_cap_reg);
        if (cap7 == 7'd0) cap7 = 7'd1;
        if (cap7 > 7'(SLOTS_PER_BLOCK)) cap7 = 7'(SLOTS_PER_BLOCK);
        nb_eff  = NBW'(nb13);
        cap_eff = FW'(cap7);
    end

    // state
    t_state r_state, n_state, r_after, n_after;
    logic              r_mode;
    logic [DBLK_W-1:0] r_dblk;
    logic [NAME_W-1:0] r_raw;
    logic [BKW-1:0]    r_bkt;
    logic [IW-1:0]     r_cur, n_cur;
    logic [CW-1:0]     r_alloc, n_alloc;
    logic [CLRW-1:0]   r_clr;
    logic [FW-1:0]     r_fill, r_i;
    logic [IW-1:0]     r_nxt;
    logic              r_has;
    logic [VISIT_W-1:0] r_visit;
    logic [MATCH_W-1:0] r_match;
    logic              r_trunc;
    logic [AW-1:0]     r_saddr;

    // pending result
    t_status           r_p_st, n_p_st;
    logic [DBLK_W-1:0] r_p_rb, n_p_rb;
    logic [VISIT_W-1:0] r_p_bv, n_p_bv;
    logic              r_p_last, n_p_last;

    // output register
    logic               r_ov;
    t_status            r_o_st;
    logic [DBLK_W-1:0]  r_o_rb;
    logic [VISIT_W-1:0] r_o_bv;
    logic               r_o_last;

    // hash unit
    logic              hash_done;
    logic [NAME_W-1:0] hash_name;
    logic [BKW-1:0]    hash_bkt;
    logic              hash_start;
    logic              r_hash_go;

    assign hash_start = (r_state == S_HASH) && !hash_done && !r_hash_go;

    chbi_hash #(.NAME_CHARS(NAME_CHARS), .NBW(NBW), .BKW(BKW)) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_name   (r_raw),
        .i_nb     (nb_eff),
        .o_done   (hash_done),
        .o_name   (hash_name),
        .o_bucket (hash_bkt)
    );

    logic [NAME_W-1:0] r_name;

    // memories
    logic [IW-1:0]  head_mem [MAX_BUCKETS];
    logic [IW-1:0]  head_q;
    logic           head_we;
    logic [BKW-1:0] head_wa;
    logic [IW-1:0]  head_wd;

    logic [BIW-1:0] binfo_mem [MAX_BLOCKS];
    logic [BIW-1:0] binfo_q;
    logic           binfo_we;
    logic [IW-1:0]  binfo_wa;
    logic [BIW-1:0] binfo_wd;

    logic [SW-1:0]  slot_mem [MAX_BLOCKS * SLOTS_PER_BLOCK];
    logic [SW-1:0]  slot_q;
    logic           slot_we;
    logic [AW-1:0]  slot_wa;

    always_ff @(posedge i_clk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        head_q <= head_mem[r_bkt];
    end
    always_ff @(posedge i_clk) begin
        if (binfo_we) binfo_mem[binfo_wa] <= binfo_wd;
        binfo_q <= binfo_mem[r_cur];
    end
    always_ff @(posedge i_clk) begin
        if (slot_we) slot_mem[slot_wa] <= {r_name, r_dblk};
        slot_q <= slot_mem[r_saddr];
    end

    logic [FW-1:0] q_fill;
    logic [IW-1:0] q_next;
    logic          q_has;
    assign {q_fill, q_next, q_has} = binfo_q;

    logic          out_free;
    logic          store_full;
    logic [IW-1:0] new_id;
    assign out_free   = !r_ov || o_res.ready;
    assign store_full = (32'(r_alloc) >= MAX_BLOCKS);
    assign new_id     = IW'(r_alloc);

    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_cur    = r_cur;
        n_alloc  = r_alloc;
        n_p_st   = r_p_st;
        n_p_rb   = r_p_rb;
        n_p_bv   = r_p_bv;
        n_p_last = r_p_last;
        head_we  = 1'b0;
        head_wa  = r_bkt;
        head_wd  = new_id;
        binfo_we = 1'b0;
        binfo_wa = r_cur;
        binfo_wd = '0;
        slot_we  = 1'b0;
        slot_wa  = AW'(AW'(r_cur) * AW'(SLOTS_PER_BLOCK) + AW'(q_fill));
        unique case (r_state)
            S_CLR: begin
                head_we = 1'b1;
                head_wa = BKW'(r_clr);
                head_wd = '0;
                if (32'(r_clr) == MAX_BUCKETS - 1) n_state = S_IDLE;
            end
            S_IDLE: if (i_req.valid) n_state = S_HASH;
            S_HASH: if (hash_done) n_state = S_HEAD_RD;
            S_HEAD_RD: n_state = S_HEAD;
            S_HEAD: begin
                if (r_mode == MODE_INSERT) begin
                    if (head_q != '0) begin
                        n_cur   = head_q;
                        n_state = S_WALK_RD;
                    end else if (store_full) begin
                        n_p_st = ST_FULL; n_p_rb = '0; n_p_bv = '0; n_p_last = 1'b1;
                        n_after = S_IDLE; n_state = S_EMIT;
                    end else begin
                        head_we  = 1'b1;
                        binfo_we = 1'b1;
                        binfo_wa = new_id;
                        binfo_wd = '0;
                        n_cur    = new_id;
                        n_alloc  = r_alloc + CW'(1);
                        n_state  = S_WALK_RD;
                    end
                end else if (head_q == '0) begin
                    n_p_st = ST_NOT_FOUND; n_p_rb = '0; n_p_bv = '0; n_p_last = 1'b1;
                    n_after = S_IDLE; n_state = S_EMIT;
                end else begin
                    n_cur   = head_q;
                    n_state = S_LBLK_RD;
                end
            end
            S_WALK_RD: n_state = S_WALK;
            S_WALK: begin
                if (q_has) begin
                    n_cur   = q_next;
                    n_state = S_WALK_RD;
                end else if (q_fill < cap_eff) begin
                    slot_we  = 1'b1;
                    binfo_we = 1'b1;
                    binfo_wd = {FW'(q_fill + FW'(1)), q_next, q_has};
                    n_p_st = ST_INSERTED; n_p_rb = DBLK_W'(r_cur); n_p_bv = '0;
                    n_p_last = 1'b1;
                    n_after = S_IDLE; n_state = S_EMIT;
                end else if (store_full) begin
                    n_p_st = ST_FULL; n_p_rb = '0; n_p_bv = '0; n_p_last = 1'b1;
                    n_after = S_IDLE; n_state = S_EMIT;
                end else begin
                    binfo_we = 1'b1;
                    binfo_wd = {q_fill, new_id, 1'b1};
                    n_cur    = new_id;
                    n_alloc  = r_alloc + CW'(1);
                    n_state  = S_LINK;
                end
            end
            S_LINK: begin
                // fresh overflow block takes the pair in its first slot
                binfo_we = 1'b1;
                binfo_wd = {FW'(1), IW'(0), 1'b0};
                slot_we  = 1'b1;
                slot_wa  = AW'(AW'(r_cur) * AW'(SLOTS_PER_BLOCK));
                n_p_st = ST_INSERTED; n_p_rb = DBLK_W'(r_cur); n_p_bv = '0; n_p_last = 1'b1;
                n_after = S_IDLE; n_state = S_EMIT;
            end
            S_LBLK_RD: n_state = S_LBLK;
            S_LBLK: n_state = (q_fill == '0) ? S_LNEXT : S_LSLOT_RD;
            S_LSLOT_RD: n_state = S_LSLOT;
            S_LSLOT: begin
                n_state = S_LADV;
                if (slot_q[SW-1:DBLK_W] == r_name && r_match != MAX_MATCHES) begin
                    n_p_st = ST_MATCH; n_p_rb = slot_q[DBLK_W-1:0]; n_p_bv = '0;
                    n_p_last = 1'b0;
                    n_after = S_LADV; n_state = S_EMIT;
                end
            end
            S_LADV: n_state = ((r_i + FW'(1)) < r_fill) ? S_LSLOT_RD : S_LNEXT;
            S_LNEXT: begin
                if (r_has) begin
                    n_cur   = r_nxt;
                    n_state = S_LBLK_RD;
                end else begin
                    n_p_st   = r_trunc ? ST_TRUNC : ((r_match != '0) ? ST_DONE : ST_NOT_FOUND);
                    n_p_rb   = '0;
                    n_p_bv   = r_visit;
                    n_p_last = 1'b1;
                    n_after  = S_IDLE;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: if (out_free) n_state = r_after;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_after   <= S_IDLE;
            r_clr     <= '0;
            r_alloc   <= CW'(1);
            r_ov      <= 1'b0;
            r_hash_go <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_alloc <= n_alloc;
            if (r_state == S_CLR) r_clr <= r_clr + CLRW'(1);
            r_hash_go <= (r_state == S_HASH) && !hash_done;
            if (r_state == S_EMIT && out_free) r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_p_st   <= n_p_st;
        r_p_rb   <= n_p_rb;
        r_p_bv   <= n_p_bv;
        r_p_last <= n_p_last;
        if (r_state == S_IDLE && i_req.valid) begin
            r_mode <= i_req.mode;
            r_dblk <= i_req.data_block;
            r_raw  <= {i_req.name_high, i_req.name_low};
        end
        if (hash_done) begin
            r_name <= hash_name;
            r_bkt  <= hash_bkt;
        end
        if (r_state == S_HEAD) begin
            r_visit <= '0;
            r_match <= '0;
            r_trunc <= 1'b0;
        end
        if (r_state == S_LBLK) begin
            if (r_visit != '1) r_visit <= r_visit + VISIT_W'(1);
            r_fill  <= (32'(q_fill) > SLOTS_PER_BLOCK) ? FW'(SLOTS_PER_BLOCK) : q_fill;
            r_nxt   <= q_next;
            r_has   <= q_has;
            r_i     <= '0;
            r_saddr <= AW'(AW'(r_cur) * AW'(SLOTS_PER_BLOCK));
        end
        if (r_state == S_LSLOT && slot_q[SW-1:DBLK_W] == r_name) begin
            if (r_match != MAX_MATCHES) r_match <= r_match + MATCH_W'(1);
            else r_trunc <= 1'b1;
        end
        if (r_state == S_LADV) begin
            r_i     <= r_i + FW'(1);
            r_saddr <= r_saddr + AW'(1);
        end
        if (r_state == S_EMIT && out_free) begin
            r_o_st   <= r_p_st;
            r_o_rb   <= r_p_rb;
            r_o_bv   <= r_p_bv;
            r_o_last <= r_p_last;
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_ov;
    assign o_res.status         = r_o_st;
    assign o_res.result_block   = r_o_rb;
    assign o_res.blocks_visited = r_o_bv;
    assign o_res.last           = r_o_last;
endmodule

/* rtl/core/chbi_chk.sv */
// Port-level checks for the hash index core, bound into the core module.
`timescale 1ns / 1ps
module chbi_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_ready,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [chbi_pkg::STATUS_W-1:0] i_status,
    input logic [chbi_pkg::VISIT_W-1:0]  i_visited,
    input logic                          i_last
);
    import chbi_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_ins_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_status == ST_INSERTED || i_status == ST_FULL) |-> i_last)
        else $error("insert result not final");

    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_status == ST_MATCH |-> !i_last && i_visited == '0)
        else $error("bad match result");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_status <= ST_TRUNC)
        else $error("status code out of range");

    a_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request taken during head clear");
endmodule

bind chained_bucket_hash_index_core chbi_chk u_chbi_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_visited   (o_res.blocks_visited),
    .i_last      (o_res.last)
);

/* tb/chbi_checker.sv */
// Checker for the hash index: predicts results from accepted requests and compares.
`timescale 1ns / 1ps
module chbi_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    chbi_req_if  req,
    chbi_res_if  res,
    chbi_cfg_if  cfg,
    output int   o_errors,
    output int   o_pending
);
    import chbi_pkg::*;

    localparam int BLOCKS = 256;
    localparam int SLOTS  = 32;
    localparam int BUCKETS = 256;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DBLK_W-1:0]   result_block;
        logic [VISIT_W-1:0]  blocks_visited;
        logic                last;
    } t_result;

    t_result expected_results[$];

    int unsigned                  head_of[BUCKETS];
    logic [NAME_LOW_W-1:0]        key_low[BLOCKS*SLOTS];
    logic [NAME_HIGH_W-1:0]       key_high[BLOCKS*SLOTS];
    logic [DBLK_W-1:0]            key_block[BLOCKS*SLOTS];
    int unsigned                  fill_of[BLOCKS];
    int unsigned                  next_of[BLOCKS];
    bit                           linked[BLOCKS];
    int unsigned                  used_blocks;
    logic [NB_REG_W-1:0]          bucket_count;
    logic [CAP_REG_W-1:0]         capacity;

    assign o_pending = expected_results.size();

    // Bytes after the first NUL count as NUL; returns the byte sum.
    function automatic int unsigned clean_name(input logic [NAME_LOW_W-1:0] lo,
                                               input logic [NAME_HIGH_W-1:0] hi,
                                               output logic [NAME_LOW_W-1:0] nlo,
                                               output logic [NAME_HIGH_W-1:0] nhi);
        logic [NAME_W-1:0] raw;
        logic [NAME_W-1:0] cl;
        logic [7:0] b;
        bit ended;
        int unsigned s;
        raw = {hi, lo};
        cl = '0;
        ended = 0;
        s = 0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            b = raw[8*i +: 8];
            if (b == 8'd0) ended = 1;
            if (!ended) begin
                cl[8*i +: 8] = b;
                s += b;
            end
        end
        nlo = cl[NAME_LOW_W-1:0];
        nhi = cl[NAME_W-1:NAME_LOW_W];
        return s;
    endfunction

    function automatic t_result mk(input t_status st, input int unsigned rb,
                                   input int unsigned bv, input logic lst);
        t_result r;
        r.status = st;
        r.result_block = rb[DBLK_W-1:0];
        r.blocks_visited = bv[VISIT_W-1:0];
        r.last = lst;
        return r;
    endfunction

    function automatic bit grab_block(output int unsigned id);
        if (used_blocks >= BLOCKS) return 0;
        id = used_blocks;
        used_blocks++;
        fill_of[id] = 0;
        next_of[id] = 0;
        linked[id] = 0;
        return 1;
    endfunction

    function automatic void put_pair(input int unsigned blk, input logic [NAME_LOW_W-1:0] lo,
                                     input logic [NAME_HIGH_W-1:0] hi,
                                     input logic [DBLK_W-1:0] db);
        int unsigned s;
        s = blk * SLOTS + fill_of[blk];
        key_low[s] = lo;
        key_high[s] = hi;
        key_block[s] = db;
        fill_of[blk]++;
    endfunction

    task automatic index_request(input logic mode, input logic [NAME_LOW_W-1:0] lo,
                                 input logic [NAME_HIGH_W-1:0] hi,
                                 input logic [DBLK_W-1:0] db);
        logic [NAME_LOW_W-1:0] nlo;
        logic [NAME_HIGH_W-1:0] nhi;
        int unsigned nb, cap, b, cur, id, visited, match_cnt, s, fill;
        bit trunc;
        nb = bucket_count;
        cap = capacity;
        if (nb == 0) nb = 1;
        if (nb > BUCKETS) nb = BUCKETS;
        if (cap == 0) cap = 1;
        if (cap > SLOTS) cap = SLOTS;
        b = clean_name(lo, hi, nlo, nhi) % nb;
        cur = head_of[b];
        if (mode == MODE_INSERT) begin
            if (cur == 0) begin
                if (!grab_block(id)) begin
                    expected_results.push_back(mk(ST_FULL, 0, 0, 1));
                    return;
                end
                head_of[b] = id;
                cur = id;
            end
            for (int n = 0; n < BLOCKS && linked[cur]; n++) cur = next_of[cur];
            if (fill_of[cur] < cap) begin
                put_pair(cur, nlo, nhi, db);
                expected_results.push_back(mk(ST_INSERTED, cur, 0, 1));
                return;
            end
            if (!grab_block(id)) begin
                expected_results.push_back(mk(ST_FULL, 0, 0, 1));
                return;
            end
            next_of[cur] = id;
            linked[cur] = 1;
            put_pair(id, nlo, nhi, db);
            expected_results.push_back(mk(ST_INSERTED, id, 0, 1));
        end else begin
            visited = 0;
            match_cnt = 0;
            trunc = 0;
            if (cur != 0) begin
                for (int n = 0; n < BLOCKS; n++) begin
                    if (visited < 255) visited++;
                    fill = (fill_of[cur] > SLOTS) ? SLOTS : fill_of[cur];
                    for (int i = 0; i < fill; i++) begin
                        s = cur * SLOTS + i;
                        if (key_low[s] == nlo && key_high[s] == nhi) begin
                            if (match_cnt < MAX_MATCHES) begin
                                expected_results.push_back(mk(ST_MATCH, key_block[s], 0, 0));
                                match_cnt++;
                            end else begin
                                trunc = 1;
                            end
                        end
                    end
                    if (!linked[cur]) break;
                    cur = next_of[cur];
                end
            end
            expected_results.push_back(mk(trunc ? ST_TRUNC :
                                          (match_cnt != 0 ? ST_DONE : ST_NOT_FOUND),
                                          0, visited, 1));
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            for (int i = 0; i < BUCKETS; i++) head_of[i] = 0;
            used_blocks = 1;
            bucket_count = 16;
            capacity = 25;
            expected_results.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_NUM_BUCKETS) bucket_count = cfg.data[NB_REG_W-1:0];
                else capacity = cfg.data[CAP_REG_W-1:0];
            end
            if (res.valid && res.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: status %0d", res.status);
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (res.status !== e.status) begin
                        $error("status expected %0d got %0d", e.status, res.status);
                        o_errors++;
                    end
                    if (res.result_block !== e.result_block) begin
                        $error("result_block expected %0d got %0d",
                               e.result_block, res.result_block);
                        o_errors++;
                    end
                    if (res.blocks_visited !== e.blocks_visited) begin
                        $error("blocks_visited expected %0d got %0d",
                               e.blocks_visited, res.blocks_visited);
                        o_errors++;
                    end
                    if (res.last !== e.last) begin
                        $error("last expected %0d got %0d", e.last, res.last);
                        o_errors++;
                    end
                end
            end
            if (req.valid && req.ready)
                index_request(req.mode, req.name_low, req.name_high, req.data_block);
        end
    end

    initial o_errors = 0;
endmodule

/* tb/tb.sv */
// Top of the hash index testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
    import chbi_pkg::*;

    localparam logic MODE_LOOKUP = ~MODE_INSERT;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    logic [NAME_W-1:0] name_pool[12];

    chbi_req_if req_if();
    chbi_res_if res_if();
    chbi_cfg_if cfg_if();

    chained_bucket_hash_index_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    chbi_checker checker_inst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .req      (req_if),
        .res      (res_if),
        .cfg      (cfg_if),
        .o_errors (errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Name of the given length; optional junk after the terminating NUL.
    function automatic logic [NAME_W-1:0] make_name(input int unsigned len, input bit junk,
                                                    input bit narrow);
        logic [NAME_W-1:0] n;
        n = '0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (i < len)
                n[8*i +: 8] = narrow ? 8'($urandom_range(97, 100)) : 8'($urandom_range(1, 255));
            else if (junk && i > len)
                n[8*i +: 8] = 8'($urandom);
        end
        return n;
    endfunction

    // Result side: random stalls, sometimes long open stretches.
    initial begin
        res_if.ready <= 0;
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                res_if.ready <= 1;
                repeat ($urandom_range(20, 200)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                res_if.ready <= 0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end
        end
    end

    task automatic send(input logic m, input logic [NAME_W-1:0] nm, input logic [15:0] db);
        int unsigned g;
        req_if.valid <= 1;
        req_if.mode <= m;
        req_if.name_low <= nm[NAME_LOW_W-1:0];
        req_if.name_high <= nm[NAME_W-1:NAME_LOW_W];
        req_if.data_block <= db;
        do @(posedge i_clk); while (!req_if.ready);
        g = gap_len();
        if (g > 0) begin
            req_if.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        req_if.valid <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_if.valid <= 1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 0;
    endtask

    task automatic random_request(input int unsigned insert_pct);
        logic [NAME_W-1:0] nm;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) nm = name_pool[$urandom_range(0, 11)];
        else if (r < 90) nm = make_name($urandom_range(0, 15), 1'($urandom_range(0, 1)), 0);
        else nm = NAME_W'({$urandom, $urandom, $urandom, $urandom});
        send(($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_LOOKUP, nm,
             16'($urandom));
    endtask

    initial begin
        logic [NAME_W-1:0] nm;
        i_rst_n <= 0;
        req_if.valid <= 0;
        req_if.mode <= MODE_INSERT;
        req_if.name_low <= '0;
        req_if.name_high <= '0;
        req_if.data_block <= '0;
        cfg_if.valid <= 0;
        cfg_if.index <= REG_NUM_BUCKETS;
        cfg_if.data <= '0;
        for (int i = 0; i < 12; i++) name_pool[i] = make_name($urandom_range(1, 4), 0, 1);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes of names and block numbers at reset settings
        nm = {NAME_W{1'b1}};
        send(MODE_INSERT, nm, 16'hFFFF);
        send(MODE_LOOKUP, nm, 16'h0000);
        send(MODE_INSERT, '0, 16'h0000);
        send(MODE_LOOKUP, '0, 16'hFFFF);
        nm = '0;
        nm[7:0] = 8'h78;
        send(MODE_INSERT, nm, 16'h1234);
        nm[NAME_W-1:16] = (NAME_W-16)'({$urandom, $urandom, $urandom, $urandom});
        send(MODE_LOOKUP, nm, 16'h0);
        send(MODE_INSERT, nm, 16'h4321);
        send(MODE_LOOKUP, make_name(1, 0, 0) | 120'h78, 16'h0);
        send(MODE_LOOKUP, make_name(15, 0, 0), 16'h0);
        for (int i = 0; i < 6; i++) send(MODE_INSERT, name_pool[i], 16'($urandom));
        for (int i = 0; i < 6; i++) send(MODE_LOOKUP, name_pool[i], 16'h0);

        // widest table, capacity clamped high
        write_reg(REG_NUM_BUCKETS, 9'd511);
        write_reg(REG_BLOCK_CAP, 9'd63);
        for (int i = 0; i < 150; i++) begin
            random_request(55);
            if (i == 75) drain();
        end

        // one bucket, one pair per block: long chains, truncation, then store full
        write_reg(REG_NUM_BUCKETS, 9'd0);
        write_reg(REG_BLOCK_CAP, 9'd0);
        for (int i = 0; i < 70; i++) send(MODE_INSERT, name_pool[0], 16'($urandom));
        send(MODE_LOOKUP, name_pool[0], 16'h0);
        for (int i = 0; i < 150; i++) random_request(80);
        send(MODE_LOOKUP, name_pool[0], 16'h0);

        // mid settings after the store has run out
        write_reg(REG_NUM_BUCKETS, 9'd300);
        write_reg(REG_BLOCK_CAP, 9'd32);
        for (int i = 0; i < 25; i++) random_request(50);
        write_reg(REG_NUM_BUCKETS, 9'd1);
        write_reg(REG_BLOCK_CAP, 9'd1);
        for (int i = 0; i < 10; i++) random_request(40);

        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/chbi_pkg.sv
rtl/core/chbi_ifs.sv
rtl/core/chbi_hash.sv
rtl/core/chained_bucket_hash_index_core.sv
rtl/core/chbi_chk.sv
tb/chbi_checker.sv
tb/tb.sv
